// ----- hdl/multilevel_temporal_binning_mean_rms_unit_defines.svh -----
// Assertion helpers used by the checker file of the binning unit.
`ifndef MULTILEVEL_TEMPORAL_BINNING_MEAN_RMS_UNIT_DEFINES_SVH
`define MULTILEVEL_TEMPORAL_BINNING_MEAN_RMS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mtb_pkg.sv -----
package mtb_pkg;

	// fixed field widths
	localparam int PIXEL_BITS = 16;
	localparam int MASK_BITS  = 9;
	localparam int EXP_W      = 4;
	localparam int SUM_W      = 24;
	localparam int SQ_W       = 40;
	localparam int WORD_W     = SUM_W + SQ_W;
	localparam int CNT_W      = 9;
	localparam int FP_W       = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int LVL_IDX_W  = 2;
	localparam int PIX_IDX_W  = 16;
	localparam int MEAN_W     = 24;
	localparam int RMS_W      = 23;
	localparam int PROD_W     = 48;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MASK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd1;

	// reset values and saturation limits
	localparam logic [MASK_BITS-1:0] LEVEL_MASK_RST   = 9'd48;
	localparam logic [FP_W-1:0]      FRAME_PIXELS_RST = 17'h10000;
	localparam logic [MEAN_W-1:0]    MEAN_MAX         = 24'hFFFF00;
	localparam logic [RMS_W-1:0]     RMS_MAX          = 23'h7FFFFF;

	// enabled levels, lowest set bits first
	typedef struct packed {
		logic [3:0]                         count;
		logic [MASK_BITS-1:0][EXP_W-1:0]    exps;
	} level_map_t;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
	} back_status_t;

	function automatic level_map_t map_levels(logic [MASK_BITS-1:0] mask, int unsigned limit);
		level_map_t  m;
		int unsigned k;
		m = '0;
		k = 0;
		for (int i = 0; i < MASK_BITS; i++) begin
			if (mask[i] && k < limit) begin
				m.exps[k] = EXP_W'(i);
				k++;
			end
		end
		m.count = 4'(k);
		return m;
	endfunction

endpackage

// ----- hdl/mtb_isqrt.sv -----
module mtb_isqrt
	import mtb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0] v_q;
	logic [RAD_W-1:0] r_q;
	logic [RAD_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] trial;
	logic             ge;

	// one result bit per cycle
	assign trial = r_q + bit_q;
	assign ge    = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q == RAD_W'(1)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

// ----- hdl/mtb_queue.sv -----
module mtb_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] data_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = data_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wr_q] <= push_data;
	end

endmodule

// ----- hdl/mtb_front.sv -----
module mtb_front
	import mtb_pkg::*;
#(
	parameter int ML = 4,
	parameter int MP = 65536,
	parameter int PW = 16,
	parameter int NW = 3,
	parameter int IW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel_value,
	input  back_status_t          status,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [IW-1:0]         push_data
);

	localparam int SZW = $clog2(MP + 1);
	localparam int CW  = (SZW > FP_W) ? SZW : FP_W;

	logic [MASK_BITS-1:0]       mask_q;
	logic [FP_W-1:0]            frame_q;
	logic [PW-1:0]              pos_q;
	logic [ML-1:0]              comp_q;
	logic [CNT_W-1:0]           fc_q [ML];

	level_map_t                 lm;
	logic [NW-1:0]              n;
	logic [ML-1:0][EXP_W-1:0]   exps_v;
	logic [ML-1:0]              low_mask;
	logic [CW-1:0]              size;
	logic [CW-1:0]              pos_inc;
	logic                       wrap;
	logic [CNT_W-1:0]           nc [ML+1];
	logic [ML-1:0]              comp_new;
	logic [ML-1:0]              comp_use;
	logic                       accept;
	logic                       start_frame;

	// level map from the mask
	always_comb begin
		lm = map_levels(mask_q, ML);
		n  = NW'(lm.count);
		for (int b = 0; b < ML; b++) begin
			exps_v[b]   = lm.exps[b];
			low_mask[b] = NW'(b) < n;
		end
	end

	// frame size and position wrap
	always_comb begin
		size    = (frame_q == '0 || CW'(frame_q) > CW'(MP)) ? CW'(MP) : CW'(frame_q);
		pos_inc = CW'(pos_q) + CW'(1);
		wrap    = pos_inc >= size;
	end

	// frame counts at frame start, finest level first
	always_comb begin
		nc[ML] = '0;
		for (int b = 0; b < ML; b++) nc[b] = fc_q[b];
		nc[0]    = nc[0] + CNT_W'(1);
		comp_new = '0;
		for (int b = 0; b < ML; b++) begin
			if (NW'(b) < n && nc[b] == (CNT_W'(1) << exps_v[b])) begin
				comp_new[b] = 1'b1;
				if (NW'(b + 1) < n) nc[b + 1] = nc[b + 1] + nc[b];
				nc[b] = '0;
			end
		end
	end

	assign start_frame = (n != '0) && (pos_q == '0);
	assign comp_use    = (start_frame ? comp_new : comp_q) & low_mask;
	assign in_ready    = push_ready && !status.clearing;
	assign accept      = in_valid && in_ready;
	assign push_valid  = in_valid && !status.clearing && (n != '0);
	assign push_data   = {pixel_value, pos_q, comp_use, n, exps_v};
	assign cfg_ready   = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= LEVEL_MASK_RST;
			frame_q <= FRAME_PIXELS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEVEL_MASK:   mask_q  <= cfg_data[MASK_BITS-1:0];
				REG_FRAME_PIXELS: frame_q <= cfg_data[FP_W-1:0];
				default: ;
			endcase
		end
	end

	// position, frame counts and completing set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			comp_q <= '0;
			for (int b = 0; b < ML; b++) fc_q[b] <= '0;
		end else if (accept) begin
			pos_q <= wrap ? '0 : PW'(pos_inc);
			if (start_frame) begin
				comp_q <= comp_new;
				for (int b = 0; b < ML; b++) fc_q[b] <= nc[b];
			end
		end
	end

endmodule

// ----- hdl/mtb_back.sv -----
module mtb_back
	import mtb_pkg::*;
#(
	parameter int ML = 4,
	parameter int MP = 65536,
	parameter int PW = 16,
	parameter int NW = 3,
	parameter int IW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  logic [IW-1:0]         pop_data,
	output back_status_t          status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LVL_IDX_W-1:0]  level_index,
	output logic [PIX_IDX_W-1:0]  pixel_index,
	output logic [MEAN_W-1:0]     mean_q8,
	output logic [RMS_W-1:0]      rms_q8,
	output logic                  last_result
);

	localparam int LW = (ML > 1) ? $clog2(ML) : 1;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LVL  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_SUB  = 3'd5;
	localparam logic [2:0] S_SQRT = 3'd6;

	logic [2:0]                state_q;
	logic [PW-1:0]             clr_q;
	logic [LW-1:0]             lvl_q;
	logic                      done_q;

	// current item
	logic [PW-1:0]             item_pos_q;
	logic [ML-1:0]             item_comp_q;
	logic [NW-1:0]             item_n_q;
	logic [ML-1:0][EXP_W-1:0]  item_exps_q;
	logic [SUM_W-1:0]          carry_sum_q;
	logic [SQ_W-1:0]           carry_sq_q;

	// queue entry fields
	logic [PIXEL_BITS-1:0]     q_pix;
	logic [PW-1:0]             q_pos;
	logic [ML-1:0]             q_comp;
	logic [NW-1:0]             q_n;
	logic [ML-1:0][EXP_W-1:0]  q_exps;
	logic [2*PIXEL_BITS-1:0]   pix_sq;

	// level banks
	logic [WORD_W-1:0]         rd_q [ML];
	logic [PW-1:0]             wr_addr;
	logic [WORD_W-1:0]         wr_data;
	logic [SUM_W-1:0]          val_sum;
	logic [SQ_W-1:0]           val_sq;
	logic                      comp_now;
	logic                      last_now;
	logic [ML-1:0]             above;

	// result path
	logic [SUM_W-1:0]          res_sum_q;
	logic [SQ_W-1:0]           res_sq_q;
	logic [EXP_W-1:0]          res_exp_q;
	logic [LW-1:0]             res_lvl_q;
	logic                      res_last_q;
	logic [PROD_W-1:0]         ss_q;
	logic [PROD_W-1:0]         lhs_q;
	logic [MEAN_W-1:0]         mean_s2;
	logic [PROD_W-1:0]         ss_c;
	logic [31:0]               mean_ext;
	logic [PROD_W-1:0]         diff;
	logic [RAD_W-1:0]          radicand;
	logic                      sq_start;
	logic                      sq_done;
	logic [ROOT_W-1:0]         root;
	logic                      out_free;
	logic                      load_out;

	logic                      out_valid_q;
	logic [LVL_IDX_W-1:0]      out_lvl_q;
	logic [PIX_IDX_W-1:0]      out_pix_q;
	logic [MEAN_W-1:0]         out_mean_q;
	logic [RMS_W-1:0]          out_rms_q;
	logic                      out_last_q;

	assign {q_pix, q_pos, q_comp, q_n, q_exps} = pop_data;
	assign pix_sq = q_pix * q_pix;

	assign status.clearing = state_q == S_CLR;
	assign pop_ready       = state_q == S_IDLE;

	// level walk: add the carry, emit or keep, pass upward
	assign val_sum  = rd_q[lvl_q][SUM_W-1:0] + carry_sum_q;
	assign val_sq   = rd_q[lvl_q][WORD_W-1:SUM_W] + carry_sq_q;
	assign comp_now = item_comp_q[lvl_q];
	assign last_now = lvl_q == LW'(item_n_q - NW'(1));
	assign above    = item_comp_q >> lvl_q;

	assign wr_addr = (state_q == S_CLR) ? clr_q : item_pos_q;
	assign wr_data = (state_q == S_LVL && !comp_now) ? {val_sq, val_sum} : '0;

	for (genvar b = 0; b < ML; b++) begin : g_bank
		logic [WORD_W-1:0] mem [MP];
		logic              we;
		assign we = (state_q == S_CLR) || (state_q == S_LVL && lvl_q == LW'(b));
		always_ff @(posedge clk) begin
			if (we) mem[wr_addr] <= wr_data;
			rd_q[b] <= mem[item_pos_q];
		end
	end

	// mean, variance term and radicand
	assign ss_c     = res_sum_q * res_sum_q;
	assign mean_ext = 32'(res_sum_q) << (4'd8 - res_exp_q);
	assign diff     = (lhs_q > ss_q) ? lhs_q - ss_q : '0;
	assign radicand = RAD_W'(diff) << (5'd16 - 5'({res_exp_q, 1'b0}));
	assign sq_start = state_q == S_SUB;

	mtb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (root)
	);

	assign out_free = !out_valid_q || out_ready;
	assign load_out = state_q == S_SQRT && sq_done && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			lvl_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(MP - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					lvl_q <= '0;
					if (pop_valid) state_q <= S_RD;
				end
				S_RD: state_q <= S_LVL;
				S_LVL: begin
					lvl_q <= lvl_q + LW'(1);
					if (comp_now) begin
						done_q  <= last_now;
						state_q <= S_MUL;
					end else if (last_now) begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: state_q <= S_SUB;
				S_SUB: state_q <= S_SQRT;
				S_SQRT: begin
					if (load_out) state_q <= done_q ? S_IDLE : S_LVL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and level datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop_valid) begin
			item_pos_q  <= q_pos;
			item_comp_q <= q_comp;
			item_n_q    <= q_n;
			item_exps_q <= q_exps;
			carry_sum_q <= SUM_W'(q_pix);
			carry_sq_q  <= SQ_W'(pix_sq);
		end
		if (state_q == S_LVL) begin
			carry_sum_q <= comp_now ? val_sum : '0;
			carry_sq_q  <= comp_now ? val_sq : '0;
			if (comp_now) begin
				res_sum_q  <= val_sum;
				res_sq_q   <= val_sq;
				res_exp_q  <= item_exps_q[lvl_q];
				res_lvl_q  <= lvl_q;
				res_last_q <= (above >> 1) == '0;
			end
		end
		if (state_q == S_MUL) begin
			ss_q    <= ss_c;
			lhs_q   <= PROD_W'(res_sq_q) << res_exp_q;
			mean_s2 <= (mean_ext > 32'(MEAN_MAX)) ? MEAN_MAX : mean_ext[MEAN_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_lvl_q  <= LVL_IDX_W'(res_lvl_q);
			out_pix_q  <= PIX_IDX_W'(item_pos_q);
			out_mean_q <= mean_s2;
			out_rms_q  <= (root > ROOT_W'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];
			out_last_q <= res_last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign level_index = out_lvl_q;
	assign pixel_index = out_pix_q;
	assign mean_q8     = out_mean_q;
	assign rms_q8      = out_rms_q;
	assign last_result = out_last_q;

endmodule

// ----- hdl/multilevel_temporal_binning_mean_rms_unit.sv -----
// Per-pixel temporal binning with mean and RMS at up to MAX_LEVELS time scales.
// Input channel: in_valid/in_ready with pixel_value, one pixel per transaction,
// raster order. Configuration channel: cfg_valid/cfg_ready with cfg_index and
// cfg_data (index 0 level_mask, index 1 frame_pixels); write only while idle.
// Output channel: out_valid/out_ready with level_index, pixel_index, mean_q8,
// rms_q8 and last_result; a pixel gives zero to MAX_LEVELS results.
// A front end keeps the pixel position and frame counts and tags each pixel
// with its completing levels; a two-entry queue decouples it from the back
// end, which does a read-modify-write of the level banks one level a cycle
// while no level completes. Per pixel the back end reads the banks, then
// walks the enabled levels; each completing level also passes the multiply,
// subtract and bit-serial square root states before its result is offered.
// After reset the banks are cleared one row per cycle, all MAX_PIXELS rows,
// during which in_ready is low; configuration writes are still taken.
// When the receiver stalls, the output register holds, the back end stops at
// the next result and the queue fills, then in_ready drops.
module multilevel_temporal_binning_mean_rms_unit
	import mtb_pkg::*;
#(
	parameter int MAX_LEVELS = 4,
	parameter int MAX_PIXELS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LVL_IDX_W-1:0]  level_index,
	output logic [PIX_IDX_W-1:0]  pixel_index,
	output logic [MEAN_W-1:0]     mean_q8,
	output logic [RMS_W-1:0]      rms_q8,
	output logic                  last_result
);

	localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int NW = $clog2(MAX_LEVELS + 1);
	localparam int IW = PIXEL_BITS + PW + MAX_LEVELS + NW + MAX_LEVELS * EXP_W;

	back_status_t  status;
	logic          push_valid;
	logic          push_ready;
	logic [IW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [IW-1:0] pop_data;

	mtb_front #(
		.ML (MAX_LEVELS),
		.MP (MAX_PIXELS),
		.PW (PW),
		.NW (NW),
		.IW (IW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.status      (status),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	mtb_queue #(
		.W (IW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mtb_back #(
		.ML (MAX_LEVELS),
		.MP (MAX_PIXELS),
		.PW (PW),
		.NW (NW),
		.IW (IW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level_index (level_index),
		.pixel_index (pixel_index),
		.mean_q8     (mean_q8),
		.rms_q8      (rms_q8),
		.last_result (last_result)
	);

endmodule

// ----- hdl/mtb_checker.sv -----
`include "multilevel_temporal_binning_mean_rms_unit_defines.svh"

module mtb_checker
	import mtb_pkg::*;
#(
	parameter int MAX_LEVELS = 4
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [PIXEL_BITS-1:0] pixel_value,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [LVL_IDX_W-1:0]  level_index,
	input logic [PIX_IDX_W-1:0]  pixel_index,
	input logic [MEAN_W-1:0]     mean_q8,
	input logic [RMS_W-1:0]      rms_q8,
	input logic                  last_result
);

	// a stalled result stays offered
	`MTB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// a stalled result keeps its values
	`MTB_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(mean_q8) && $stable(rms_q8) && $stable(pixel_index), "result changed while stalled")

	// mean never passes the saturation limit
	`MTB_ASSERT_NOW(a_mean_sat, clk, arst_n, out_valid, mean_q8 <= MEAN_MAX, "mean above saturation limit")

	// the coarsest level is always the last result of its pixel
	`MTB_ASSERT_NOW(a_top_last, clk, arst_n, out_valid && (MAX_LEVELS <= 4) && (level_index == LVL_IDX_W'(MAX_LEVELS - 1)), last_result, "coarsest level not marked last")

endmodule

bind multilevel_temporal_binning_mean_rms_unit mtb_checker #(.MAX_LEVELS(MAX_LEVELS)) u_mtb_checker (.*);

// ----- tb/multilevel_temporal_binning_mean_rms_unit_tb.sv -----
`timescale 1ns / 1ps

module multilevel_temporal_binning_mean_rms_unit_tb;
	import mtb_pkg::*;

	localparam int NUM_SLOTS   = 4;
	localparam int PIXELS_MAX  = 65536;
	localparam int DRAIN_WAIT  = 400;
	localparam int STALL_LIMIT = 400000;
	localparam int HOLD_LEN    = 3000;

	typedef struct {
		logic [LVL_IDX_W-1:0] level;
		logic [PIX_IDX_W-1:0] pixel;
		logic [MEAN_W-1:0]    mean;
		logic [RMS_W-1:0]     rms;
		logic                 last;
	} bin_stat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIXEL_BITS-1:0] pixel_value;
	logic                  out_valid;
	logic                  out_ready;
	logic [LVL_IDX_W-1:0]  level_index;
	logic [PIX_IDX_W-1:0]  pixel_index;
	logic [MEAN_W-1:0]     mean_q8;
	logic [RMS_W-1:0]      rms_q8;
	logic                  last_result;

	// predictor state
	bit [SUM_W-1:0]     sum_bank [0:NUM_SLOTS*PIXELS_MAX-1];
	bit [SQ_W-1:0]      sq_bank  [0:NUM_SLOTS*PIXELS_MAX-1];
	bit [CNT_W-1:0]     frame_count [0:NUM_SLOTS-1];
	bit [15:0]          next_pos;
	bit [NUM_SLOTS-1:0] completing;
	bit [MASK_BITS-1:0] mask_reg;
	bit [FP_W-1:0]      frame_reg;

	bin_stat_t pending_stats[$];
	int        fail_count;
	int        send_idle;
	int        recv_idle;
	int        hold_request;
	int        hold_left;
	int        quiet_cycles;

	multilevel_temporal_binning_mean_rms_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level_index (level_index),
		.pixel_index (pixel_index),
		.mean_q8     (mean_q8),
		.rms_q8      (rms_q8),
		.last_result (last_result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// integer square root, bit by bit
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// update the per-pixel bins for one pixel and queue the stats it releases
	function automatic void bin_pixel(logic [PIXEL_BITS-1:0] v);
		int              exps [0:NUM_SLOTS-1];
		int              n;
		int unsigned     size;
		int              pos;
		int              at;
		int              e;
		int              before_n;
		longint unsigned s, q, mean, lhs, ss, d, rms;
		bin_stat_t       st;
		n = 0;
		for (int i = 0; i < MASK_BITS; i++) begin
			if (mask_reg[i] && n < NUM_SLOTS) begin
				exps[n] = i;
				n++;
			end
		end
		size = (frame_reg == 0 || frame_reg > PIXELS_MAX) ? PIXELS_MAX : frame_reg;
		pos = next_pos;
		before_n = pending_stats.size();
		if (n > 0) begin
			// frame start: bump the frame counts and cascade the full ones
			if (pos == 0) begin
				completing = '0;
				frame_count[0] = frame_count[0] + 1'b1;
				for (int b = 0; b < n; b++) begin
					if (frame_count[b] == (1 << exps[b])) begin
						completing[b] = 1'b1;
						if (b + 1 < n)
							frame_count[b+1] = frame_count[b+1] + frame_count[b];
						frame_count[b] = '0;
					end
				end
			end
			sum_bank[pos] = sum_bank[pos] + v;
			sq_bank[pos]  = sq_bank[pos] + SQ_W'(v) * SQ_W'(v);
			for (int b = 0; b < n; b++) begin
				if (completing[b]) begin
					at = b * PIXELS_MAX + pos;
					s = sum_bank[at];
					q = sq_bank[at];
					e = exps[b];
					if (b + 1 < n) begin
						sum_bank[at+PIXELS_MAX] = sum_bank[at+PIXELS_MAX] + s;
						sq_bank[at+PIXELS_MAX]  = sq_bank[at+PIXELS_MAX] + q;
					end
					mean = s << (8 - e);
					if (mean > MEAN_MAX)
						mean = MEAN_MAX;
					lhs = q << e;
					ss = s * s;
					d = (lhs > ss) ? lhs - ss : 0;
					rms = floor_sqrt(d << (16 - 2 * e));
					if (rms > RMS_MAX)
						rms = RMS_MAX;
					st.level = LVL_IDX_W'(b);
					st.pixel = PIX_IDX_W'(pos);
					st.mean = MEAN_W'(mean);
					st.rms = RMS_W'(rms);
					st.last = 1'b0;
					pending_stats.push_back(st);
					sum_bank[at] = '0;
					sq_bank[at]  = '0;
				end
			end
			if (pending_stats.size() > before_n)
				pending_stats[pending_stats.size()-1].last = 1'b1;
		end
		next_pos = (pos + 1 >= size) ? 16'd0 : 16'(pos + 1);
	endfunction

	// one pixel transaction, with random gaps before it
	task automatic send_pixel(input logic [PIXEL_BITS-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (!in_ready);
		bin_pixel(v);
	endtask

	function automatic logic [PIXEL_BITS-1:0] rand_pixel();
		case ($urandom_range(5))
			0: return '1;
			1: return '0;
			2: return PIXEL_BITS'($urandom_range(255));
			default: return PIXEL_BITS'($urandom);
		endcase
	endfunction

	// register write; caller ends the burst with end_writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LEVEL_MASK)
			mask_reg = MASK_BITS'(val);
		else if (idx == REG_FRAME_PIXELS)
			frame_reg = FP_W'(val);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
	endtask

	// stop offering pixels and let every expected stat come out
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic configure(input int unsigned mask, input int unsigned frame);
		write_reg(REG_LEVEL_MASK, mask);
		write_reg(REG_FRAME_PIXELS, frame);
		end_writes();
	endtask

	// extremes of the pixel, finest level only and every level enabled
	task automatic test_extremes();
		drain();
		configure(1, 3);
		send_pixel('0);
		send_pixel('1);
		send_pixel(16'h5555);
		send_pixel(16'hAAAA);
		send_pixel(16'h00FF);
		send_pixel(16'hFF00);
		drain();
		configure(511, 2);
		for (int i = 0; i < 8; i++)
			send_pixel(i[0] ? '1 : 16'h0001);
		drain();
	endtask

	// no level enabled, then an out-of-range frame size and a mid-frame shrink
	task automatic test_special_cases();
		configure(0, 4);
		send_pixel(16'h1234);
		send_pixel('1);
		drain();
		configure(3, 0);
		send_pixel(16'h0F0F);
		send_pixel('1);
		drain();
		configure(3, 131071);
		send_pixel(16'h8000);
		drain();
		configure(2, 1);
		send_pixel(16'h0101);
		send_pixel(16'h7FFF);
		drain();
	endtask

	// random masks and small frames
	task automatic test_random(input int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			configure($urandom_range(3) == 0 ? $urandom_range(1, 511) : $urandom_range(1, 15),
				$urandom_range(4) == 0 ? $urandom_range(7, 40) : $urandom_range(1, 6));
			for (int i = 0; i < 30; i++)
				send_pixel(rand_pixel());
			sent += 30;
			drain();
		end
	endtask

	// receiver holds off while pixels keep coming, so the input stalls
	task automatic test_backpressure();
		configure(15, 2);
		hold_request = HOLD_LEN;
		for (int i = 0; i < 40; i++)
			send_pixel(rand_pixel());
		drain();
	endtask

	// a coarse level: 128 one-pixel frames
	task automatic test_coarsest_level();
		configure(128, 1);
		for (int i = 0; i < 129; i++)
			send_pixel('1);
		drain();
	endtask

	// output side: random ready, or a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left <= hold_request;
			hold_request = 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// compare each stat transaction with the oldest prediction
	always @(posedge clk) begin
		bin_stat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected stat: level %0d pixel %0d mean %0d rms %0d last %0d",
					$time, level_index, pixel_index, mean_q8, rms_q8, last_result);
				fail_count++;
			end else begin
				want = pending_stats.pop_front();
				if (want.level !== level_index || want.pixel !== pixel_index ||
						want.mean !== mean_q8 || want.rms !== rms_q8 ||
						want.last !== last_result) begin
					$display("%0t: expected level %0d pixel %0d mean %0d rms %0d last %0d",
						$time, want.level, want.pixel, want.mean, want.rms, want.last);
					$display("%0t: actual   level %0d pixel %0d mean %0d rms %0d last %0d",
						$time, level_index, pixel_index, mean_q8, rms_q8, last_result);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("multilevel_temporal_binning_mean_rms_unit regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_LEVEL_MASK;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel_value  = '0;
		fail_count   = 0;
		hold_request = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		next_pos     = '0;
		completing   = '0;
		mask_reg     = LEVEL_MASK_RST;
		frame_reg    = FRAME_PIXELS_RST;
		for (int i = 0; i < NUM_SLOTS; i++)
			frame_count[i] = '0;
		send_idle    = 29;
		recv_idle    = 47;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_special_cases();
		test_random(60);
		send_idle = 47;
		recv_idle = 29;
		test_random(60);
		test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		test_random(30);
		test_coarsest_level();

		if (fail_count == 0)
			$display("multilevel_temporal_binning_mean_rms_unit regression: pass");
		else
			$display("multilevel_temporal_binning_mean_rms_unit regression: fail");
		$finish;
	end

endmodule
